### hw/rtl/log_record_reformatter_defines.svh
// Assertion macros for the log record reformatter RTL.
`ifndef LOG_RECORD_REFORMATTER_DEFINES_SVH
`define LOG_RECORD_REFORMATTER_DEFINES_SVH

`ifndef SYNTH

// The condition must never hold while out of reset.
`define LRR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define LRR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds, cons must hold in the following cycle.
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define LRR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/lrr_pkg.sv
// Types, character codes and sizes shared by the log record reformatter.
`default_nettype none

package lrr_pkg;

    localparam int LRR_LINE_DEPTH = 63;

    // Command queue between the parser and the line engine.
    localparam int LRR_CMDQ_DEPTH = 4;
    localparam int LRR_CMDQ_AW    = 2;
    localparam int LRR_CMDQ_CW    = 3;

    // Result queue at the output of the line engine.
    localparam int LRR_OQ_DEPTH = 4;
    localparam int LRR_OQ_AW    = 2;
    localparam int LRR_OQ_CW    = 3;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       truncated;
    } out_word_t;

    typedef enum logic [3:0] {
        P_SKIP  = 4'd0,
        P_START = 4'd1,
        P_HRS1  = 4'd2,
        P_HRS2  = 4'd3,
        P_MIN1  = 4'd4,
        P_MIN2  = 4'd5,
        P_SEC1  = 4'd6,
        P_SEC2  = 4'd7,
        P_ID    = 4'd8,
        P_VAL   = 4'd9
    } pos_t;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_PUT2,
        CMD_CLEAR,
        CMD_EMIT
    } cmd_op_t;

    // One parsed action. clr_first empties the line before the operation.
    typedef struct packed {
        logic       clr_first;
        cmd_op_t    op;
        logic [7:0] ch1;
        logic [7:0] ch2;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SECOND,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/log_record_reformatter.sv
// A closing ';' passes the command queue, and the line engine reads out the line, then a newline.
// Throughput: one input byte per cycle while the four-entry command queue has room;
// the line engine handles one command at a time, writing an inserted separator in BK_SECOND, and a
// line of L bytes drains as L+1 words, one store read per cycle while the result queue has room.
// Reset (rst_n low, asynchronous) returns the parser to the skip position and empties the
// line and both queues; the line store contents are not cleared.
`default_nettype none

`include "log_record_reformatter_defines.svh"

module log_record_reformatter
    import lrr_pkg::*;
#(
    parameter int LINE_DEPTH = LRR_LINE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_word_t  in_data,
    output logic           empty,
    input  wire logic      pop,
    output out_word_t      out_data
);

    // The front end classifies each accepted word into at most one line command. It only
    // stalls when the command queue is full, so bytes keep flowing while a line drains until that queue fills.
    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_head;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    lrr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_data  (in_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in)
    );

    lrr_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    // The line engine owns the store, the length and the overflow flag. It writes at most one
    // byte per cycle and, on an emit command, reads the line back into a small result
    // queue that feeds the output ports.
    lrr_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

    // The front end must never write a command the queue cannot hold.
    `LRR_ASSERT_NEVER(a_no_cmd_overrun, clk, rst_n, cmd_push && cmd_full, "command queue overrun")

    // A full command queue stays full until the line engine takes a command.
    `LRR_ASSERT_NEXT(a_full_holds, clk, rst_n, cmd_full && !cmd_pop && !cmd_push, cmd_full, "command queue lost an entry")

    // The word that closes a line is always the newline.
    `LRR_ASSERT_IMPLY(a_last_is_newline, clk, rst_n, !empty && out_data.last, out_data.out_byte == CH_LF, "closing word is not a newline")

endmodule

`default_nettype wire

### hw/rtl/lrr_front.sv
// Parser front end: tracks the field position and turns each byte into at most one line command.
`default_nettype none

module lrr_front
    import lrr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_word_t in_data,
    output logic          cmd_push,
    output cmd_t          cmd_data
);

    pos_t pos_reg;
    pos_t pos_next;
    pos_t base_pos;
    logic has_cmd;

    // A new text starts from the skip position before the byte is handled.
    assign base_pos = in_data.new_text ? P_SKIP : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (in_data.in_byte)
                CH_DOT, CH_SPACE, CH_TAB, CH_LF, CH_CR: pos_next = base_pos;
                CH_COLON:  pos_next = P_ID;
                CH_EQUALS: pos_next = P_VAL;
                CH_SEMI:   pos_next = P_HRS1;
                CH_PLUS:   pos_next = P_SKIP;
                default:
                begin
                    unique case (base_pos)
                        P_HRS1:  pos_next = P_HRS2;
                        P_HRS2:  pos_next = P_MIN1;
                        P_MIN1:  pos_next = P_MIN2;
                        P_MIN2:  pos_next = P_SEC1;
                        P_SEC1:  pos_next = P_SEC2;
                        P_SEC2:  pos_next = P_ID;
                        P_ID:    pos_next = P_SKIP;
                        default: pos_next = base_pos;
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        has_cmd            = 1'b0;
        cmd_data.clr_first = in_data.new_text;
        cmd_data.op        = CMD_CLEAR;
        cmd_data.ch1       = in_data.in_byte;
        cmd_data.ch2       = CH_COLON;
        unique case (in_data.in_byte)
            CH_DOT:
            begin
                has_cmd      = 1'b1;
                cmd_data.op  = CMD_PUT;
                cmd_data.ch1 = CH_COMMA;
            end
            CH_COLON, CH_EQUALS, CH_SPACE, CH_TAB:
            begin
                has_cmd = 1'b0;
            end
            CH_SEMI:
            begin
                has_cmd     = 1'b1;
                cmd_data.op = (base_pos != P_SKIP) ? CMD_EMIT : CMD_CLEAR;
            end
            CH_PLUS, CH_LF, CH_CR:
            begin
                has_cmd     = 1'b1;
                cmd_data.op = CMD_CLEAR;
            end
            default:
            begin
                unique case (base_pos)
                    P_HRS1, P_MIN1, P_SEC1, P_VAL:
                    begin
                        has_cmd     = 1'b1;
                        cmd_data.op = CMD_PUT;
                    end
                    P_HRS2, P_MIN2:
                    begin
                        has_cmd      = 1'b1;
                        cmd_data.op  = CMD_PUT2;
                        cmd_data.ch2 = CH_COLON;
                    end
                    P_SEC2, P_ID:
                    begin
                        has_cmd      = 1'b1;
                        cmd_data.op  = CMD_PUT2;
                        cmd_data.ch2 = CH_SEMI;
                    end
                    default:
                    begin
                        has_cmd = 1'b0;
                    end
                endcase
            end
        endcase
        // A new text that otherwise does nothing still has to empty the line.
        if (in_data.new_text && !has_cmd)
        begin
            has_cmd     = 1'b1;
            cmd_data.op = CMD_CLEAR;
        end
        cmd_push = accept && has_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= P_SKIP;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lrr_cmd_queue.sv
// Short command queue that decouples the parser from the line engine.
`default_nettype none

module lrr_cmd_queue
    import lrr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    cmd_t                   entry_mem [LRR_CMDQ_DEPTH];
    logic [LRR_CMDQ_AW-1:0] wr_ptr_reg;
    logic [LRR_CMDQ_AW-1:0] wr_ptr_next;
    logic [LRR_CMDQ_AW-1:0] rd_ptr_reg;
    logic [LRR_CMDQ_AW-1:0] rd_ptr_next;
    logic [LRR_CMDQ_CW-1:0] cnt_reg;
    logic [LRR_CMDQ_CW-1:0] cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (cnt_reg == LRR_CMDQ_CW'(LRR_CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = entry_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + LRR_CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + LRR_CMDQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + LRR_CMDQ_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - LRR_CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lrr_back.sv
// Line engine: holds the line store, applies commands and drains finished lines.
`default_nettype none

module lrr_back
    import lrr_pkg::*;
#(
    parameter int LINE_DEPTH = LRR_LINE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd_head,
    output logic      cmd_pop,
    output logic      empty,
    input  wire logic pop,
    output out_word_t out_data
);

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int LEN_W = $clog2(LINE_DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [7:0]       line_mem [LINE_DEPTH];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [7:0]       ch2_reg;
    logic [7:0]       ch2_next;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] rd_idx_next;
    logic             rd_vld_reg;
    logic [7:0]       rd_data_reg;

    logic [LEN_W-1:0] base_len;
    logic             base_ovf;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_issue;
    logic             nl_push;

    out_word_t              oq_mem [LRR_OQ_DEPTH];
    logic [LRR_OQ_AW-1:0]   oq_wr_reg;
    logic [LRR_OQ_AW-1:0]   oq_wr_next;
    logic [LRR_OQ_AW-1:0]   oq_rd_reg;
    logic [LRR_OQ_AW-1:0]   oq_rd_next;
    logic [LRR_OQ_CW-1:0]   oq_cnt_reg;
    logic [LRR_OQ_CW-1:0]   oq_cnt_next;
    logic [LRR_OQ_CW-1:0]   oq_occ;
    logic                   oq_push;
    out_word_t              oq_din;
    logic                   oq_pop;

    assign base_len = cmd_head.clr_first ? '0 : len_reg;
    assign base_ovf = cmd_head.clr_first ? 1'b0 : ovf_reg;

    // Slots already used plus a read that lands next cycle.
    assign oq_occ   = oq_cnt_reg + LRR_OQ_CW'(rd_vld_reg);
    assign rd_issue = (state_reg == BK_EMIT) && (rd_idx_reg != len_reg)
                      && (oq_occ < LRR_OQ_CW'(LRR_OQ_DEPTH));
    assign nl_push  = (state_reg == BK_EMIT) && (rd_idx_reg == len_reg) && !rd_vld_reg
                      && (oq_cnt_reg < LRR_OQ_CW'(LRR_OQ_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd_head.op == CMD_PUT2)
                    begin
                        state_next = BK_SECOND;
                    end
                    else if (cmd_head.op == CMD_EMIT)
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_SECOND:
            begin
                state_next = BK_IDLE;
            end
            BK_EMIT:
            begin
                if (nl_push)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = 1'b0;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        ch2_next    = ch2_reg;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = len_reg[AW-1:0];
        wr_data     = ch2_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    len_next = base_len;
                    ovf_next = base_ovf;
                    ch2_next = cmd_head.ch2;
                    unique case (cmd_head.op)
                        CMD_PUT, CMD_PUT2:
                        begin
                            if (base_len < LEN_W'(LINE_DEPTH))
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = base_len[AW-1:0];
                                wr_data  = cmd_head.ch1;
                                len_next = base_len + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                        CMD_EMIT:
                        begin
                            rd_idx_next = '0;
                        end
                        default:
                        begin
                            len_next = base_len;
                        end
                    endcase
                end
            end
            BK_SECOND:
            begin
                if (len_reg < LEN_W'(LINE_DEPTH))
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            BK_EMIT:
            begin
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + LEN_W'(1);
                end
                // The line is emptied once its closing newline is queued.
                if (nl_push)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    // Result queue: stored bytes arrive in the cycle after their read, the newline directly.
    always_comb
    begin
        oq_push          = rd_vld_reg || nl_push;
        oq_din.out_byte  = rd_vld_reg ? rd_data_reg : CH_LF;
        oq_din.last      = !rd_vld_reg;
        oq_din.truncated = ovf_reg;
        oq_pop           = pop && !empty;
        oq_wr_next       = oq_push ? oq_wr_reg + LRR_OQ_AW'(1) : oq_wr_reg;
        oq_rd_next       = oq_pop ? oq_rd_reg + LRR_OQ_AW'(1) : oq_rd_reg;
        oq_cnt_next      = oq_cnt_reg;
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + LRR_OQ_CW'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = oq_cnt_reg - LRR_OQ_CW'(1);
        end
    end

    assign empty    = (oq_cnt_reg == '0);
    assign out_data = oq_mem[oq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= line_mem[rd_idx_reg[AW-1:0]];
        end
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= oq_din;
        end
        ch2_reg    <= ch2_next;
        rd_idx_reg <= rd_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            rd_vld_reg <= rd_issue;
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

`default_nettype wire

### bench/log_record_reformatter_tb.sv
// Self-checking testbench for the log record reformatter.
`timescale 1ns / 1ps

module log_record_reformatter_tb;

    import lrr_pkg::*;

    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] ID_FALLBACK = 8'h78;
    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 150;
    // The receiver hold-off starts once this many bytes went in, while the
    // sender still offers a byte on every cycle.
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      push = 1'b0;
    logic      full;
    in_word_t  in_data = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_word_t out_data;

    // Bytes of log text still to be offered, and the output words that the
    // bytes accepted so far must still produce, oldest first.
    in_word_t  text_bytes[$];
    out_word_t line_words_due[$];

    // Our own copy of the parser position and the line being built.
    pos_t       fmt_pos;
    logic [7:0] fmt_line [LRR_LINE_DEPTH];
    int         fmt_len;
    logic       fmt_ovf;

    int item_total;
    int words_in;
    int idle_phase;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    logic hold_done;
    int full_stalls;
    int words_checked;
    int lines_seen;
    int lines_truncated;
    int errors;

    log_record_reformatter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    always #5 clk = ~clk;

    // Append one character to the line, or note that the line overflowed.
    task automatic store_char(input logic [7:0] c);
        if (fmt_len < LRR_LINE_DEPTH)
        begin
            fmt_line[fmt_len] = c;
            fmt_len++;
        end
        else
        begin
            fmt_ovf = 1'b1;
        end
    endtask

    // Advance the parser by one accepted byte and queue the words that a
    // closing semicolon releases: every stored byte, then a newline.
    task automatic reformat_byte(input in_word_t w);
        out_word_t word;
        if (w.new_text)
        begin
            fmt_pos = P_SKIP;
            fmt_len = 0;
            fmt_ovf = 1'b0;
        end
        case (w.in_byte)
            CH_DOT:    store_char(CH_COMMA);
            CH_COLON:  fmt_pos = P_ID;
            CH_EQUALS: fmt_pos = P_VAL;
            CH_SEMI:
            begin
                if (fmt_pos != P_SKIP)
                begin
                    for (int i = 0; i < fmt_len; i++)
                    begin
                        word.out_byte  = fmt_line[i];
                        word.last      = 1'b0;
                        word.truncated = fmt_ovf;
                        line_words_due.push_back(word);
                    end
                    word.out_byte  = CH_LF;
                    word.last      = 1'b1;
                    word.truncated = fmt_ovf;
                    line_words_due.push_back(word);
                end
                fmt_len = 0;
                fmt_ovf = 1'b0;
                fmt_pos = P_HRS1;
            end
            CH_SPACE, CH_TAB:
            begin
            end
            CH_PLUS:
            begin
                fmt_pos = P_SKIP;
                fmt_len = 0;
                fmt_ovf = 1'b0;
            end
            CH_LF, CH_CR:
            begin
                // A line break empties the line but leaves the position alone.
                fmt_len = 0;
                fmt_ovf = 1'b0;
            end
            default:
            begin
                // Ordinary characters fill the time stamp, the id or a value
                // depending on where the parser stands; separators are added
                // after the second digit of each time field and after the id.
                case (fmt_pos)
                    P_HRS1:
                    begin
                        store_char(w.in_byte);
                        fmt_pos = P_HRS2;
                    end
                    P_HRS2:
                    begin
                        store_char(w.in_byte);
                        store_char(CH_COLON);
                        fmt_pos = P_MIN1;
                    end
                    P_MIN1:
                    begin
                        store_char(w.in_byte);
                        fmt_pos = P_MIN2;
                    end
                    P_MIN2:
                    begin
                        store_char(w.in_byte);
                        store_char(CH_COLON);
                        fmt_pos = P_SEC1;
                    end
                    P_SEC1:
                    begin
                        store_char(w.in_byte);
                        fmt_pos = P_SEC2;
                    end
                    P_SEC2:
                    begin
                        store_char(w.in_byte);
                        store_char(CH_SEMI);
                        fmt_pos = P_ID;
                    end
                    P_ID:
                    begin
                        store_char(w.in_byte);
                        store_char(CH_SEMI);
                        fmt_pos = P_SKIP;
                    end
                    P_VAL:
                    begin
                        store_char(w.in_byte);
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input logic nt);
        in_word_t w;
        w.in_byte  = b;
        w.new_text = nt;
        text_bytes.push_back(w);
    endtask

    // A random printable character that the parser treats as ordinary text, or a dot.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7e));
        if (c == CH_SEMI || c == CH_COLON || c == CH_EQUALS || c == CH_PLUS)
            c = ID_FALLBACK;
        return c;
    endfunction

    // Sender. The byte at the head of text_bytes is what push offers; it
    // leaves the queue, and goes through the predictor, on the edge at which
    // the block takes it. push changes at most once per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_data <= '0;
        end
        else
        begin : send
            logic offer;
            if (push && !full)
            begin
                reformat_byte(in_data);
                void'(text_bytes.pop_front());
                words_in++;
            end
            if (push && full)
                full_stalls++;
            // The run walks through four idling phases by progress:
            // none, sender idle, receiver stalling, then both lightly.
            idle_phase = (words_in * 4) / item_total;
            if (idle_phase > 3)
                idle_phase = 3;
            case (idle_phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            offer = (text_bytes.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            push <= offer;
            if (offer)
                in_data <= text_bytes[0];
        end
    end

    // One long receiver hold-off, counted here, so that finished lines back
    // up through the output and command queues until full rises.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_in >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver. Every word taken is compared with the oldest expected word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin : receive
            out_word_t want;
            if (pop && !empty)
            begin
                if (line_words_due.size() == 0)
                begin
                    $error("unexpected word: out_byte %h last %b truncated %b",
                           out_data.out_byte, out_data.last, out_data.truncated);
                    errors++;
                end
                else
                begin
                    want = line_words_due.pop_front();
                    words_checked++;
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %h, got %h",
                               want.out_byte, out_data.out_byte);
                        errors++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last mismatch: expected %b, got %b", want.last, out_data.last);
                        errors++;
                    end
                    if (out_data.truncated !== want.truncated)
                    begin
                        $error("truncated mismatch: expected %b, got %b",
                               want.truncated, out_data.truncated);
                        errors++;
                    end
                    if (want.last)
                    begin
                        lines_seen++;
                        if (want.truncated)
                            lines_truncated++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int r;
        int n;
        logic long_done;

        fmt_pos = P_SKIP;
        fmt_len = 0;
        fmt_ovf = 1'b0;
        words_in = 0;
        idle_phase = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        full_stalls = 0;
        words_checked = 0;
        lines_seen = 0;
        lines_truncated = 0;
        errors = 0;
        long_done = 1'b0;

        // Directed text. A semicolon while skipping releases nothing; the
        // time stamp gets its separators; space and tab vanish; a dot turns
        // into a comma even while skipping; colon and equals jump to the id
        // and value positions; the extreme byte values pass as text.
        add_byte(CH_SEMI, 1'b1);
        add_byte(DIGIT_ZERO + 8'd1, 1'b0);
        add_byte(DIGIT_ZERO + 8'd2, 1'b0);
        add_byte(DIGIT_ZERO + 8'd3, 1'b0);
        add_byte(DIGIT_ZERO + 8'd4, 1'b0);
        add_byte(DIGIT_ZERO + 8'd5, 1'b0);
        add_byte(DIGIT_ZERO + 8'd6, 1'b0);
        add_byte(CH_SPACE, 1'b0);
        add_byte(CH_TAB, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(CH_DOT, 1'b0);
        add_byte(CH_COLON, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_EQUALS, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(CH_SEMI, 1'b0);
        // Plus empties the line and skips, so the next semicolon is silent.
        add_byte(CH_PLUS, 1'b0);
        add_byte(DIGIT_ZERO + 8'd9, 1'b0);
        add_byte(CH_SEMI, 1'b0);
        // Line breaks empty the line but keep the position.
        add_byte(DIGIT_ZERO, 1'b0);
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
        add_byte(DIGIT_ZERO + 8'd7, 1'b0);
        // New text drops the pending line; the following semicolon then
        // releases an empty line, just the newline.
        add_byte(CH_SEMI, 1'b1);
        add_byte(CH_SEMI, 1'b0);

        // Random text: mostly well-formed records with random content, some
        // of them with long values that overflow the line, and some noise.
        while (text_bytes.size() < DIRECTED_BYTES + RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                add_byte(CH_SEMI, $urandom_range(0, 19) == 0);
                for (int k = 0; k < 6; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
                    add_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                end
                add_byte(plain_char(), 1'b0);
                r = $urandom_range(0, 9);
                if (r < 5)
                begin
                    add_byte(CH_EQUALS, 1'b0);
                    if (!long_done || $urandom_range(0, 9) == 0)
                        n = $urandom_range(45, 70);
                    else
                        n = $urandom_range(0, 8);
                    long_done = 1'b1;
                    for (int k = 0; k < n; k++)
                        add_byte(($urandom_range(0, 4) == 0) ? CH_DOT : plain_char(), 1'b0);
                end
                else if (r < 7)
                begin
                    add_byte(CH_COLON, 1'b0);
                    add_byte(plain_char(), 1'b0);
                end
                else if (r == 7)
                begin
                    add_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
                end
                else if (r == 8)
                begin
                    add_byte(CH_PLUS, 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
            end
        end
        // Flush whatever line is still being built.
        add_byte(CH_SEMI, 1'b0);
        item_total = text_bytes.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (text_bytes.size() != 0)
            @(posedge clk);
        for (int c = 0; c < DRAIN_LIMIT && line_words_due.size() != 0; c++)
            @(posedge clk);
        // A few more cycles so that any stray word still gets caught.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (line_words_due.size() != 0)
        begin
            $error("%0d expected words never arrived", line_words_due.size());
            errors++;
        end

        $display("Fed %0d text bytes, checked %0d words in %0d lines, %0d of them truncated.",
                 words_in, words_checked, lines_seen, lines_truncated);
        $display("Input was held off by a full block on %0d cycles.", full_stalls);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lrr_pkg.sv
hw/rtl/lrr_front.sv
hw/rtl/lrr_cmd_queue.sv
hw/rtl/lrr_back.sv
hw/rtl/log_record_reformatter.sv
bench/log_record_reformatter_tb.sv
